// ===== design/pnq_pkg.sv =====
// Package for the palette nearest-color quantizer.
// Holds palette sizing, color constants and the distance pipeline type.
// No dependencies; every other design file imports it.
package pnq_pkg;

  // Palette sizing.
  localparam int PALETTE_ENTRIES = 256;
  localparam int PAL_AW          = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
  localparam int IDX_W           = 8;
  localparam int COMP_W          = 8;
  localparam int ENTRY_W         = 3 * COMP_W;
  localparam int SQ_W            = 2 * COMP_W;
  // Three squared 8-bit differences sum to at most 195075, below 2**18.
  localparam int DIST_W          = SQ_W + 2;
  localparam int COUNT_W         = 32;

  // Transparency rules.
  localparam logic [COMP_W-1:0] ALPHA_LIMIT    = 8'd128;
  localparam logic [COMP_W-1:0] FULL_COMPONENT = 8'd255;

  // A squared distance tagged with the palette entry it belongs to.
  typedef struct packed {
    logic              valid;
    logic [PAL_AW-1:0] tag;
    logic [DIST_W-1:0] distance;
  } pnq_dist_t;

endpackage

// ===== design/pnq_if.sv =====
// Channel interfaces of the palette nearest-color quantizer.
// Pixel/load input, result output and configuration write channels.
// Depends on pnq_pkg for field widths.
interface pnq_pixel_if;
  import pnq_pkg::*;
  logic              valid;
  logic              ready;
  logic              mode;
  logic [IDX_W-1:0]  entry_index;
  logic [COMP_W-1:0] red;
  logic [COMP_W-1:0] green;
  logic [COMP_W-1:0] blue;
  logic [COMP_W-1:0] alpha;
  modport source (output valid, mode, entry_index, red, green, blue, alpha, input ready);
  modport sink (input valid, mode, entry_index, red, green, blue, alpha, output ready);
endinterface

interface pnq_result_if;
  import pnq_pkg::*;
  logic               valid;
  logic               ready;
  logic [IDX_W-1:0]   palette_index;
  logic               is_transparent;
  logic               is_stray;
  logic [COUNT_W-1:0] stray_count;
  modport source (output valid, palette_index, is_transparent, is_stray, stray_count,
                  input ready);
  modport sink (input valid, palette_index, is_transparent, is_stray, stray_count,
                output ready);
endinterface

interface pnq_cfg_if;
  import pnq_pkg::*;
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] transparent_index;
  modport source (output valid, transparent_index, input ready);
  modport sink (input valid, transparent_index, output ready);
endinterface

// ===== design/palette_nearest_color_quantizer.sv =====
// Top level of the palette nearest-color quantizer.
// Instantiates pnq_palette_ram and pnq_dist_unit; uses pnq_pkg and pnq_if.
//
// Usage:
// - pixel_in carries load items (mode 0) and pixel items (mode 1). A load item
//   writes one palette entry in the cycle of its transfer and gives no result;
//   an entry_index beyond the palette is dropped. Load every entry before the
//   first pixel.
// - result_out gives one result per pixel item: chosen index, transparency
//   flag, stray flag and the running saturated stray count.
// - cfg writes the transparent index at any transfer; it is always ready. The
//   user must write it only while the block is idle; the block does not enforce it.
// Timing:
// - A transparent or colorkey pixel skips the scan: it goes straight to the
//   finish state, and its result is loaded into the output register from there.
// - An opaque pixel scans the palette one entry per cycle through the single
//   memory read port and the shared distance unit, keeping a running minimum,
//   then waits for the last distance before the finish state loads its result.
// - A load item leaves the block idle, so it can take another item straight after.
// - The result sits in an output register; the block takes the next item while
//   it waits, and holds a finished result until the receiver takes it.
// Reset clears the stray count, the transparent index and all handshakes; the
// palette contents are undefined until loaded.
module palette_nearest_color_quantizer
  import pnq_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  pnq_pixel_if.sink    pixel_in,
  pnq_result_if.source result_out,
  pnq_cfg_if.sink      cfg
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_WAIT,
    S_FINISH
  } state_t;

  localparam logic [PAL_AW-1:0] PAL_LAST = PAL_AW'(PALETTE_ENTRIES - 1);

  state_t             state;
  logic [IDX_W-1:0]   transparent_index;
  logic [COUNT_W-1:0] stray_total;
  logic [PAL_AW-1:0]  scan_addr;
  logic               rd_valid;
  logic [PAL_AW-1:0]  rd_tag;
  logic [DIST_W-1:0]  best_dist;
  logic [PAL_AW-1:0]  best_idx;
  logic [COMP_W-1:0]  px_red, px_green, px_blue;
  logic               px_transp;
  logic               out_valid;
  logic [IDX_W-1:0]   out_index;
  logic               out_transp;
  logic               out_stray;
  logic [COUNT_W-1:0] out_count;

  logic               in_xfer;
  logic               load_wr;
  logic               pix_is_transp;
  logic [ENTRY_W-1:0] ram_rd_data;
  logic               finish_stray;
  logic [COUNT_W-1:0] stray_total_next;
  logic               out_free;
  pnq_dist_t          dist_res;

  // Handshakes.
  assign pixel_in.ready = (state == S_IDLE);
  assign cfg.ready      = 1'b1;
  assign in_xfer        = pixel_in.valid && pixel_in.ready;
  assign load_wr        = in_xfer && !pixel_in.mode &&
                          ({1'b0, pixel_in.entry_index} < (IDX_W + 1)'(PALETTE_ENTRIES));
  assign out_free       = !out_valid || result_out.ready;

  // Transparency test on the incoming pixel.
  assign pix_is_transp = (pixel_in.alpha < ALPHA_LIMIT) ||
                         (pixel_in.red == FULL_COMPONENT && pixel_in.green == '0 &&
                          pixel_in.blue == FULL_COMPONENT);

  // Stray decision and saturating count for the finished pixel.
  assign finish_stray     = !px_transp && (best_dist != '0);
  assign stray_total_next = (finish_stray && (stray_total != '1)) ?
                            stray_total + COUNT_W'(1) : stray_total;

  pnq_palette_ram u_ram (
    .clk     (clk),
    .wr_en   (load_wr),
    .wr_addr (pixel_in.entry_index[PAL_AW-1:0]),
    .wr_data ({pixel_in.red, pixel_in.green, pixel_in.blue}),
    .rd_en   (state == S_SCAN),
    .rd_addr (scan_addr),
    .rd_data (ram_rd_data)
  );

  pnq_dist_unit u_dist (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (rd_valid),
    .in_tag    (rd_tag),
    .entry     (ram_rd_data),
    .pix_red   (px_red),
    .pix_green (px_green),
    .pix_blue  (px_blue),
    .result    (dist_res)
  );

  // Sequencer, running minimum and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= S_IDLE;
      transparent_index <= '0;
      stray_total       <= '0;
      rd_valid          <= 1'b0;
      out_valid         <= 1'b0;
    end else begin
      if (cfg.valid) begin
        transparent_index <= cfg.transparent_index;
      end
      rd_valid <= (state == S_SCAN);
      // The result register fills when a pixel finishes and empties on transfer.
      if (state == S_FINISH && out_free) begin
        out_valid <= 1'b1;
      end else if (result_out.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_xfer && pixel_in.mode) begin
            state <= pix_is_transp ? S_FINISH : S_SCAN;
          end
        end
        S_SCAN: begin
          if (scan_addr == PAL_LAST) begin
            state <= S_WAIT;
          end
        end
        S_WAIT: begin
          if (!rd_valid && !dist_res.valid) begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (out_free) begin
            stray_total <= stray_total_next;
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end

    // Payload registers.
    rd_tag <= scan_addr;
    if (state == S_SCAN) begin
      scan_addr <= scan_addr + PAL_AW'(1);
    end
    if (in_xfer && pixel_in.mode) begin
      px_red    <= pixel_in.red;
      px_green  <= pixel_in.green;
      px_blue   <= pixel_in.blue;
      px_transp <= pix_is_transp;
      scan_addr <= '0;
      best_dist <= '1;
      best_idx  <= '0;
    end
    if (dist_res.valid && (dist_res.distance < best_dist)) begin
      best_dist <= dist_res.distance;
      best_idx  <= dist_res.tag;
    end
    if (state == S_FINISH && out_free) begin
      out_index  <= px_transp ? transparent_index : IDX_W'(best_idx);
      out_transp <= px_transp;
      out_stray  <= finish_stray;
      out_count  <= stray_total_next;
    end
  end

  assign result_out.valid          = out_valid;
  assign result_out.palette_index  = out_index;
  assign result_out.is_transparent = out_transp;
  assign result_out.is_stray       = out_stray;
  assign result_out.stray_count    = out_count;

  // The stray count never moves backward.
  a_count_monotonic: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> (stray_total >= $past(stray_total)))
    else $error("stray count decreased");

  // A transparent result is never flagged as a stray.
  a_transp_not_stray: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_transp) |-> !out_stray)
    else $error("transparent result flagged as stray");

  // Distance results only appear while a scan is in progress.
  a_dist_in_scan: assert property (@(posedge clk) disable iff (rst)
    dist_res.valid |-> (state == S_SCAN || state == S_WAIT))
    else $error("distance result outside a scan");

  // No new item is taken while a scan is running.
  a_no_accept_in_scan: assert property (@(posedge clk) disable iff (rst)
    (rd_valid || dist_res.valid) |-> !pixel_in.ready)
    else $error("input ready during scan");

endmodule

// ===== design/pnq_palette_ram.sv =====
// Palette memory: one write port and one registered read port.
// Depends on pnq_pkg for depth and entry width.
module pnq_palette_ram
  import pnq_pkg::*;
(
  input  logic               clk,
  input  logic               wr_en,
  input  logic [PAL_AW-1:0]  wr_addr,
  input  logic [ENTRY_W-1:0] wr_data,
  input  logic               rd_en,
  input  logic [PAL_AW-1:0]  rd_addr,
  output logic [ENTRY_W-1:0] rd_data
);

  logic [ENTRY_W-1:0] mem [PALETTE_ENTRIES];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== design/pnq_dist_unit.sv =====
// Shared squared-distance unit: one palette entry against the pixel per cycle.
// Squares are registered, the sum is formed on the output side.
// Depends on pnq_pkg.
module pnq_dist_unit
  import pnq_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic [PAL_AW-1:0]  in_tag,
  input  logic [ENTRY_W-1:0] entry,
  input  logic [COMP_W-1:0]  pix_red,
  input  logic [COMP_W-1:0]  pix_green,
  input  logic [COMP_W-1:0]  pix_blue,
  output pnq_dist_t          result
);

  logic [COMP_W-1:0] diff_r, diff_g, diff_b;
  logic [COMP_W-1:0] ent_r, ent_g, ent_b;
  logic [SQ_W-1:0]   sq_r, sq_g, sq_b;
  logic              sq_valid;
  logic [PAL_AW-1:0] sq_tag;

  assign ent_r = entry[3*COMP_W-1:2*COMP_W];
  assign ent_g = entry[2*COMP_W-1:COMP_W];
  assign ent_b = entry[COMP_W-1:0];

  // Absolute component differences.
  always_comb begin
    diff_r = (pix_red   > ent_r) ? (pix_red   - ent_r) : (ent_r - pix_red);
    diff_g = (pix_green > ent_g) ? (pix_green - ent_g) : (ent_g - pix_green);
    diff_b = (pix_blue  > ent_b) ? (pix_blue  - ent_b) : (ent_b - pix_blue);
  end

  // Square stage, one register after the multipliers.
  always_ff @(posedge clk) begin
    if (rst) begin
      sq_valid <= 1'b0;
    end else begin
      sq_valid <= in_valid;
    end
    sq_tag <= in_tag;
    sq_r   <= SQ_W'(diff_r) * SQ_W'(diff_r);
    sq_g   <= SQ_W'(diff_g) * SQ_W'(diff_g);
    sq_b   <= SQ_W'(diff_b) * SQ_W'(diff_b);
  end

  // Sum of the three squares.
  always_comb begin
    result.valid    = sq_valid;
    result.tag      = sq_tag;
    result.distance = DIST_W'(sq_r) + DIST_W'(sq_g) + DIST_W'(sq_b);
  end

endmodule
